// ----- hw/rtl/tpl_pkg.sv -----
// Package for the two-phase lock tracker: function, phase and status codes,
// the default table size and the control structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package tpl_pkg;

  localparam int unsigned LockSlotsDef = 16;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned IdW     = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned CountW  = 5;

  // Request functions.
  localparam logic [FuncW-1:0] FUNC_ACQUIRE = 3'd0;
  localparam logic [FuncW-1:0] FUNC_RELEASE = 3'd1;
  localparam logic [FuncW-1:0] FUNC_COMMIT  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_ABORT   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_SHRINK  = 3'd4;
  localparam logic [FuncW-1:0] FUNC_QUERY   = 3'd5;

  // Transaction phases.
  localparam logic [PhaseW-1:0] PH_GROWING   = 2'd0;
  localparam logic [PhaseW-1:0] PH_SHRINKING = 2'd1;
  localparam logic [PhaseW-1:0] PH_COMMITTED = 2'd2;
  localparam logic [PhaseW-1:0] PH_ABORTED   = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_DONE        = 3'd0;
  localparam logic [StatusW-1:0] ST_WRONG_PHASE = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_HELD    = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL        = 3'd3;
  localparam logic [StatusW-1:0] ST_COMMITTED   = 3'd4;

  // Update request from the phase controller to the slot table.
  typedef struct packed {
    logic alloc;
    logic free;
  } tbl_cmd_t;

  // Lookup results from the slot table to the phase controller.
  typedef struct packed {
    logic hit;
    logic full;
  } tbl_stat_t;

endpackage

// ----- hw/rtl/two_phase_lock_tracker.sv -----
// A request accepted into the request register moves to the result register once that
// is empty or being emptied, and waits there until out_ready_i takes it.
// Throughput: one request per cycle while results are taken; each request is resolved
// in a single pass through the slot match and phase logic between the two registers.
// Reset (rst_ni low, asynchronous): phase growing, no ids held, both stages empty.
// Depends on tpl_pkg, tpl_slot_table and tpl_phase_ctrl.
`timescale 1ns / 1ps

module two_phase_lock_tracker #(
  parameter int unsigned LOCK_SLOTS = tpl_pkg::LockSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tpl_pkg::FuncW-1:0]     func_i,
  input  logic [tpl_pkg::IdW-1:0]       resource_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [tpl_pkg::StatusW-1:0]   status_o,
  output logic [tpl_pkg::PhaseW-1:0]    phase_o,
  output logic [tpl_pkg::CountW-1:0]    lock_count_o
);
  import tpl_pkg::*;

  // Request register: holds one accepted transaction until it is resolved.
  logic              req_valid_q;
  logic [FuncW-1:0]  req_func_q;
  logic [IdW-1:0]    req_id_q;

  // Result register: holds one finished transaction until it is taken.
  logic               res_valid_q;
  logic               res_ok_q;
  logic [StatusW-1:0] res_status_q;
  logic [PhaseW-1:0]  res_phase_q;
  logic [CountW-1:0]  res_count_q;

  logic               fire;
  logic               in_fire;
  tbl_cmd_t           tbl_cmd;
  tbl_stat_t          tbl_stat;
  logic               ok;
  logic [StatusW-1:0] status;
  logic [PhaseW-1:0]  phase_next;
  logic [CountW-1:0]  count_next;

  // A held request is resolved when the result register is empty or is being
  // emptied in this cycle. The phase and the slot table update at that same
  // edge, so the next request already sees the new state.
  assign fire       = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_func_q <= func_i;
      req_id_q   <= resource_id_i;
    end
  end

  tpl_phase_ctrl u_phase_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .func_i       (req_func_q),
    .stat_i       (tbl_stat),
    .cmd_o        (tbl_cmd),
    .ok_o         (ok),
    .status_o     (status),
    .phase_next_o (phase_next)
  );

  tpl_slot_table #(
    .LOCK_SLOTS (LOCK_SLOTS)
  ) u_slot_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .id_i         (req_id_q),
    .cmd_i        (tbl_cmd),
    .stat_o       (tbl_stat),
    .count_next_o (count_next)
  );

  // The result carries the phase and lock count as they stand after the step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_ok_q     <= ok;
      res_status_q <= status;
      res_phase_q  <= phase_next;
      res_count_q  <= count_next;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign ok_o         = res_ok_q;
  assign status_o     = res_status_q;
  assign phase_o      = res_phase_q;
  assign lock_count_o = res_count_q;

endmodule

// ----- hw/rtl/tpl_slot_table.sv -----
// Slot table of the two-phase lock tracker: held ids, valid bits, fill count,
// parallel id match and lowest-free-slot pick. Depends on tpl_pkg.
`timescale 1ns / 1ps

module tpl_slot_table #(
  parameter int unsigned LOCK_SLOTS = tpl_pkg::LockSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [tpl_pkg::IdW-1:0]       id_i,
  input  tpl_pkg::tbl_cmd_t             cmd_i,
  output tpl_pkg::tbl_stat_t            stat_o,
  output logic [tpl_pkg::CountW-1:0]    count_next_o
);
  import tpl_pkg::*;

  localparam int unsigned CntW = $clog2(LOCK_SLOTS + 1);

  logic [LOCK_SLOTS-1:0] valid_q, valid_d;
  logic [IdW-1:0]        res_q [LOCK_SLOTS];
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [LOCK_SLOTS-1:0] hit_vec;
  logic [LOCK_SLOTS-1:0] free_oh;
  logic [CntW+CountW-1:0] cnt_wide;

  always_comb begin
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      hit_vec[i] = valid_q[i] && (res_q[i] == id_i);
    end
  end

  // The lowest clear bit of the valid vector marks the slot to fill.
  assign free_oh = ~valid_q & (valid_q + LOCK_SLOTS'(1));

  assign stat_o.hit  = |hit_vec;
  assign stat_o.full = &valid_q;

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (cmd_i.alloc) begin
      valid_d = valid_q | free_oh;
      cnt_d   = cnt_q + CntW'(1);
    end else if (cmd_i.free) begin
      valid_d = valid_q & ~hit_vec;
      cnt_d   = cnt_q - CntW'(1);
    end
  end

  // The reported count wraps to its five bits for large tables.
  assign cnt_wide     = (CntW + CountW)'(cnt_d);
  assign count_next_o = cnt_wide[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (cmd_i.alloc && free_oh[i]) begin
        res_q[i] <= id_i;
      end
    end
  end

endmodule

// ----- hw/rtl/tpl_phase_ctrl.sv -----
// Phase controller of the two-phase lock tracker: holds the transaction
// phase and decides each request's outcome and table update. Depends on tpl_pkg.
`timescale 1ns / 1ps

module tpl_phase_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [tpl_pkg::FuncW-1:0]     func_i,
  input  tpl_pkg::tbl_stat_t            stat_i,
  output tpl_pkg::tbl_cmd_t             cmd_o,
  output logic                          ok_o,
  output logic [tpl_pkg::StatusW-1:0]   status_o,
  output logic [tpl_pkg::PhaseW-1:0]    phase_next_o
);
  import tpl_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic              alloc, free;

  always_comb begin
    phase_d  = phase_q;
    ok_o     = 1'b0;
    status_o = ST_DONE;
    alloc    = 1'b0;
    free     = 1'b0;
    case (func_i)
      FUNC_ACQUIRE: begin
        if (phase_q != PH_GROWING) begin
          status_o = ST_WRONG_PHASE;
        end else if (stat_i.hit) begin
          ok_o = 1'b1;
        end else if (stat_i.full) begin
          status_o = ST_FULL;
        end else begin
          alloc = 1'b1;
          ok_o  = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        if (!stat_i.hit) begin
          status_o = ST_NOT_HELD;
        end else begin
          if (phase_q == PH_GROWING) begin
            phase_d = PH_SHRINKING;
          end
          free = 1'b1;
          ok_o = 1'b1;
        end
      end
      FUNC_COMMIT: begin
        if (phase_q inside {PH_GROWING, PH_SHRINKING}) begin
          phase_d = PH_COMMITTED;
          ok_o    = 1'b1;
        end else if (phase_q == PH_COMMITTED) begin
          status_o = ST_COMMITTED;
        end else begin
          status_o = ST_WRONG_PHASE;
        end
      end
      FUNC_ABORT: begin
        if (phase_q == PH_COMMITTED) begin
          status_o = ST_COMMITTED;
        end else begin
          phase_d = PH_ABORTED;
          ok_o    = 1'b1;
        end
      end
      FUNC_SHRINK: begin
        if (phase_q == PH_GROWING) begin
          phase_d = PH_SHRINKING;
          ok_o    = 1'b1;
        end else begin
          status_o = ST_WRONG_PHASE;
        end
      end
      FUNC_QUERY: begin
        if (stat_i.hit) begin
          ok_o = 1'b1;
        end else begin
          status_o = ST_NOT_HELD;
        end
      end
      default: begin
        // Unused function codes leave everything unchanged.
      end
    endcase
  end

  assign cmd_o.alloc  = fire_i && alloc;
  assign cmd_o.free   = fire_i && free;
  assign phase_next_o = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GROWING;
    end else if (fire_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- hw/rtl/tpl_checker.sv -----
// Port-level checker for the two-phase lock tracker, bound to the top level.
// Depends on tpl_pkg and two_phase_lock_tracker.
`timescale 1ns / 1ps

module tpl_checker #(
  parameter int unsigned LOCK_SLOTS = tpl_pkg::LockSlotsDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          ok_o,
  input logic [tpl_pkg::StatusW-1:0]   status_o,
  input logic [tpl_pkg::PhaseW-1:0]    phase_o,
  input logic [tpl_pkg::CountW-1:0]    lock_count_o
);
  import tpl_pkg::*;

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(phase_o))
    else $error("result changed while stalled");

  // The input only backs up behind a result that is waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

  // A successful transaction always reports done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> status_o == ST_DONE)
    else $error("ok with a failure status");

  // A full table is only reported while growing, with every slot counted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      phase_o == PH_GROWING && lock_count_o == CountW'(LOCK_SLOTS))
    else $error("table full reported inconsistently");

  // The "already committed" status is only returned in the committed phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_COMMITTED |-> phase_o == PH_COMMITTED)
    else $error("committed status outside committed phase");

endmodule

bind two_phase_lock_tracker tpl_checker #(.LOCK_SLOTS(LOCK_SLOTS)) u_tpl_checker (.*);
